@@ src/dtp_pkg.sv @@
package dtp_pkg;

  localparam int DISP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int XY_W    = 21;
  localparam int Z_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int FOCAL_W = 16;
  localparam int FB_W    = 24;

  // depth divider: (fb*16 + d/2) / d, quotient limited to Z_W bits
  localparam int ZDEN_W  = 15;
  localparam int ZNUM_W  = FB_W + 5;
  // lateral divider: (|off|*z + f/2) / f, quotient limited to XY_W bits
  localparam int MAG_W   = 16;
  localparam int PROD_W  = MAG_W + Z_W;
  localparam int LNUM_W  = PROD_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_BL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd6;

  localparam logic [FOCAL_W-1:0] RST_FOCAL_X   = 16'd7338;
  localparam logic [FOCAL_W-1:0] RST_FOCAL_Y   = 16'd7317;
  localparam logic [FOCAL_W-1:0] RST_CENTER_X  = 16'd5875;
  localparam logic [FOCAL_W-1:0] RST_CENTER_Y  = 16'd3974;
  localparam logic [FB_W-1:0]    RST_FOCAL_BL  = 24'd51698;
  localparam logic [Z_W-1:0]     RST_MIN_DEPTH = 18'd205;
  localparam logic [Z_W-1:0]     RST_MAX_DEPTH = 18'd61440;

  localparam logic [XY_W-1:0] XY_POS_MAX = 21'h0FFFFF;
  localparam logic [XY_W-1:0] XY_NEG_MIN = 21'h100000;

  // signed offset (pix*16 - center) as sign and magnitude
  function automatic logic [MAG_W:0] offset_sm(input logic [PIX_W-1:0] pix,
                                               input logic [FOCAL_W-1:0] ctr);
    logic [MAG_W+1:0] diff;
    logic [MAG_W+1:0] mag;
    diff = {2'b00, pix, 4'b0000} - {2'b00, ctr};
    mag  = diff[MAG_W+1] ? (~diff + 1'b1) : diff;
    return {diff[MAG_W+1], mag[MAG_W-1:0]};
  endfunction

  // apply sign and clamp to the XY field range
  function automatic logic [XY_W-1:0] sat_xy(input logic neg, input logic ovf,
                                             input logic [XY_W-1:0] q);
    logic [XY_W-1:0] res;
    if (neg) begin
      if (ovf || q > XY_NEG_MIN) res = XY_NEG_MIN;
      else res = ~q + 1'b1;
    end else begin
      if (ovf || q > XY_POS_MAX) res = XY_POS_MAX;
      else res = q;
    end
    return res;
  endfunction

endpackage

@@ src/dtp_in_if.sv @@
interface dtp_in_if import dtp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disparity_q4;
  logic [PIX_W-1:0]         column;
  logic [PIX_W-1:0]         row;
  modport source  (output valid, disparity_q4, column, row, input ready);
  modport sink    (input valid, disparity_q4, column, row, output ready);
  modport monitor (input valid, ready, disparity_q4, column, row);
endinterface

@@ src/dtp_out_if.sv @@
interface dtp_out_if import dtp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [XY_W-1:0] point_x_q10;
  logic signed [XY_W-1:0] point_y_q10;
  logic [Z_W-1:0]         point_z_q10;
  modport source  (output valid, point_x_q10, point_y_q10, point_z_q10, input ready);
  modport sink    (input valid, point_x_q10, point_y_q10, point_z_q10, output ready);
  modport monitor (input valid, ready, point_x_q10, point_y_q10, point_z_q10);
endinterface

@@ src/dtp_cfg_if.sv @@
interface dtp_cfg_if import dtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

@@ src/dtp_pipe_div.sv @@
// Restoring divider, one quotient bit per register stage, MSB first.
// Numerator must be below den << Q_W.
module dtp_pipe_div import dtp_pkg::*; #(
  parameter int NUM_W = ZNUM_W,
  parameter int DEN_W = ZDEN_W,
  parameter int Q_W   = Z_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             v_r   [Q_W];
  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] dsh;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign rem_ext = CMP_W'(rem_in);
    assign dsh     = CMP_W'(den_in) << (Q_W - 1 - k);
    assign ge      = rem_ext >= dsh;
    assign rem_nxt = ge ? NUM_W'(rem_ext - dsh) : rem_in;
    assign quo_nxt = quo_in | (Q_W'(ge) << (Q_W - 1 - k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

@@ src/disparity_to_point_reproject.sv @@
// Channel   Direction  Payload
// in_ch     sink       disparity_q4 s16, column u12, row u12
// out_ch    source     point_x_q10 s21, point_y_q10 s21, point_z_q10 u18
// cfg_ch    sink       index u3, data u24 (always ready)
//
// One transaction per cycle sustained unless out_ch stalls; the path holds the
// 18-stage depth divider and the 21-stage lateral dividers.
// Reset (rst_n low, synchronous) empties the pipeline and loads default calibration.
// The whole pipeline advances together; it freezes only while a result
// sits in the output register and out_ch.ready is low.
// Rejected pixels turn into bubbles and produce no output transaction.
module disparity_to_point_reproject import dtp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dtp_in_if.sink    in_ch,
  dtp_out_if.source out_ch,
  dtp_cfg_if.sink   cfg_ch
);

  // ---------------- calibration registers ----------------
  logic [FOCAL_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [FB_W-1:0]    focal_bl_r;
  logic [Z_W-1:0]     min_depth_r, max_depth_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= RST_FOCAL_X;
      focal_y_r   <= RST_FOCAL_Y;
      center_x_r  <= RST_CENTER_X;
      center_y_r  <= RST_CENTER_Y;
      focal_bl_r  <= RST_FOCAL_BL;
      min_depth_r <= RST_MIN_DEPTH;
      max_depth_r <= RST_MAX_DEPTH;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FOCAL_X:   focal_x_r   <= cfg_ch.data[FOCAL_W-1:0];
        REG_FOCAL_Y:   focal_y_r   <= cfg_ch.data[FOCAL_W-1:0];
        REG_CENTER_X:  center_x_r  <= cfg_ch.data[FOCAL_W-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_ch.data[FOCAL_W-1:0];
        REG_FOCAL_BL:  focal_bl_r  <= cfg_ch.data[FB_W-1:0];
        REG_MIN_DEPTH: min_depth_r <= cfg_ch.data[Z_W-1:0];
        REG_MAX_DEPTH: max_depth_r <= cfg_ch.data[Z_W-1:0];
        default: ;
      endcase
    end
  end

  // zero focal length behaves as one
  logic [FOCAL_W-1:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x_r == '0) ? FOCAL_W'(1) : focal_x_r;
  assign fy_eff = (focal_y_r == '0) ? FOCAL_W'(1) : focal_y_r;

  // global advance: output register empty or being drained
  logic out_valid_r;
  logic en;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 0: screen disparity, form depth numerator ----------------
  logic              disp_ok;
  logic [ZDEN_W-1:0] disp_mag;
  logic [ZNUM_W-1:0] znum;
  logic              z_big;
  logic [MAG_W:0]    offx_sm, offy_sm;

  assign disp_ok  = in_ch.disparity_q4 > $signed(DISP_W'(16));
  assign disp_mag = in_ch.disparity_q4[ZDEN_W-1:0];
  assign znum     = {1'b0, focal_bl_r, 4'b0000} + ZNUM_W'(disp_mag >> 1);
  // quotient of Z_W+ bits can never pass the depth window
  assign z_big    = (ZDEN_W + Z_W)'(znum) >= {disp_mag, {Z_W{1'b0}}};
  assign offx_sm  = offset_sm(in_ch.column, center_x_r);
  assign offy_sm  = offset_sm(in_ch.row, center_y_r);

  logic              s0_v_r;
  logic [ZNUM_W-1:0] s0_num_r;
  logic [ZDEN_W-1:0] s0_den_r;
  logic [MAG_W:0]    s0_offx_r, s0_offy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid && disp_ok && !z_big;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num_r  <= znum;
      s0_den_r  <= disp_mag;
      s0_offx_r <= offx_sm;
      s0_offy_r <= offy_sm;
    end
  end

  // ---------------- depth divider ----------------
  localparam int ZTAG_W = 2 * (MAG_W + 1);
  logic              zd_v;
  logic [Z_W-1:0]    zd_q;
  logic [ZTAG_W-1:0] zd_tag;

  dtp_pipe_div #(
    .NUM_W (ZNUM_W),
    .DEN_W (ZDEN_W),
    .Q_W   (Z_W),
    .TAG_W (ZTAG_W)
  ) u_zdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_num    (s0_num_r),
    .in_den    (s0_den_r),
    .in_tag    ({s0_offx_r, s0_offy_r}),
    .out_valid (zd_v),
    .out_quo   (zd_q),
    .out_tag   (zd_tag)
  );

  // ---------------- stage M: depth window, offset times depth ----------------
  logic [MAG_W:0] zd_offx, zd_offy;
  logic           in_window;
  assign zd_offx   = zd_tag[ZTAG_W-1 -: MAG_W+1];
  assign zd_offy   = zd_tag[MAG_W:0];
  assign in_window = (zd_q >= min_depth_r) && (zd_q <= max_depth_r);

  logic              m_v_r;
  logic [Z_W-1:0]    m_z_r;
  logic              m_negx_r, m_negy_r;
  logic [PROD_W-1:0] m_px_r, m_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= zd_v && in_window;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_z_r    <= zd_q;
      m_negx_r <= zd_offx[MAG_W];
      m_negy_r <= zd_offy[MAG_W];
      m_px_r   <= PROD_W'(zd_offx[MAG_W-1:0]) * PROD_W'(zd_q);
      m_py_r   <= PROD_W'(zd_offy[MAG_W-1:0]) * PROD_W'(zd_q);
    end
  end

  // ---------------- stage C: rounding bias, overflow screen ----------------
  localparam int LCMP_W = FOCAL_W + XY_W;
  logic [LNUM_W-1:0] numx, numy;
  logic              ovfx, ovfy;
  assign numx = LNUM_W'(m_px_r) + LNUM_W'(fx_eff >> 1);
  assign numy = LNUM_W'(m_py_r) + LNUM_W'(fy_eff >> 1);
  assign ovfx = LCMP_W'(numx) >= {fx_eff, {XY_W{1'b0}}};
  assign ovfy = LCMP_W'(numy) >= {fy_eff, {XY_W{1'b0}}};

  logic              c_v_r;
  logic [Z_W-1:0]    c_z_r;
  logic              c_negx_r, c_negy_r, c_ovfx_r, c_ovfy_r;
  logic [LNUM_W-1:0] c_numx_r, c_numy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_z_r    <= m_z_r;
      c_negx_r <= m_negx_r;
      c_negy_r <= m_negy_r;
      c_ovfx_r <= ovfx;
      c_ovfy_r <= ovfy;
      c_numx_r <= numx;
      c_numy_r <= numy;
    end
  end

  // ---------------- lateral dividers, X carries depth alongside ----------------
  localparam int XTAG_W = Z_W + 2;
  logic              xd_v, yd_v;
  logic [XY_W-1:0]   xd_q, yd_q;
  logic [XTAG_W-1:0] xd_tag;
  logic [1:0]        yd_tag;

  dtp_pipe_div #(
    .NUM_W (LNUM_W),
    .DEN_W (FOCAL_W),
    .Q_W   (XY_W),
    .TAG_W (XTAG_W)
  ) u_xdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_num    (c_numx_r),
    .in_den    (fx_eff),
    .in_tag    ({c_z_r, c_negx_r, c_ovfx_r}),
    .out_valid (xd_v),
    .out_quo   (xd_q),
    .out_tag   (xd_tag)
  );

  dtp_pipe_div #(
    .NUM_W (LNUM_W),
    .DEN_W (FOCAL_W),
    .Q_W   (XY_W),
    .TAG_W (2)
  ) u_ydiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_num    (c_numy_r),
    .in_den    (fy_eff),
    .in_tag    ({c_negy_r, c_ovfy_r}),
    .out_valid (yd_v),
    .out_quo   (yd_q),
    .out_tag   (yd_tag)
  );

  // ---------------- output register: sign and clamp ----------------
  logic [XY_W-1:0] out_x_r, out_y_r;
  logic [Z_W-1:0]  out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= xd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= sat_xy(xd_tag[1], xd_tag[0], xd_q);
      out_y_r <= sat_xy(yd_tag[1], yd_tag[0], yd_q);
      out_z_r <= xd_tag[XTAG_W-1 -: Z_W];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_x_q10 = $signed(out_x_r);
  assign out_ch.point_y_q10 = $signed(out_y_r);
  assign out_ch.point_z_q10 = out_z_r;

  // ---------------- checks ----------------
  a_z_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_z_r >= min_depth_r) && (out_z_r <= max_depth_r))
    else $error("depth outside window");

  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_z_r == '0) |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("nonzero lateral at zero depth");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    xd_v == yd_v)
    else $error("lateral dividers out of step");

endmodule

@@ bench/dtp_tb_if.sv @@
// Interfaces come from the RTL source tree (dtp_in_if, dtp_out_if, dtp_cfg_if).
// This file holds the shared bench constants.
package dtp_tb_pkg;
  import dtp_pkg::*;
  localparam int PIPE_LATENCY = 43;
  localparam int NUM_REGS     = 7;
endpackage

@@ bench/point_checker.sv @@
module point_checker import dtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dtp_in_if.monitor  in_mon,
  dtp_out_if.monitor out_mon,
  dtp_cfg_if.monitor cfg_mon,
  output int         fail_count,
  output int         pending_points
);

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
  } point_t;

  logic [FOCAL_W-1:0] fx, fy, cx, cy;
  logic [FB_W-1:0]    fb;
  logic [Z_W-1:0]     zmin, zmax;
  point_t             point_queue[$];

  // rounded |off|*z/f, tie away from zero, saturated to the XY range
  function automatic logic [XY_W-1:0] lateral_coord(input longint off,
                                                    input longint z,
                                                    input longint f);
    longint den, mag, q;
    den = (f == 0) ? 1 : f;
    mag = (off < 0) ? -off : off;
    q = (mag * z + den / 2) / den;
    if (off < 0) begin
      if (q > 1048576) q = 1048576;
      return XY_W'(-q);
    end
    if (q > 1048575) q = 1048575;
    return XY_W'(q);
  endfunction

  function automatic bit project_pixel(input logic [DISP_W-1:0] draw,
                                       input logic [PIX_W-1:0] u,
                                       input logic [PIX_W-1:0] v,
                                       output point_t p);
    longint d, z;
    d = longint'($signed(draw));
    if (d <= 16) return 0;
    z = (longint'(fb) * 16 + d / 2) / d;
    if (z < zmin || z > zmax) return 0;
    p.x = lateral_coord(longint'(u) * 16 - cx, z, fx);
    p.y = lateral_coord(longint'(v) * 16 - cy, z, fy);
    p.z = Z_W'(z);
    return 1;
  endfunction

  assign pending_points = point_queue.size();

  always @(posedge clk) begin
    point_t p, got;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      fx <= RST_FOCAL_X; fy <= RST_FOCAL_Y;
      cx <= RST_CENTER_X; cy <= RST_CENTER_Y;
      fb <= RST_FOCAL_BL; zmin <= RST_MIN_DEPTH; zmax <= RST_MAX_DEPTH;
      point_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FOCAL_X:   fx <= cfg_mon.data[FOCAL_W-1:0];
          REG_FOCAL_Y:   fy <= cfg_mon.data[FOCAL_W-1:0];
          REG_CENTER_X:  cx <= cfg_mon.data[FOCAL_W-1:0];
          REG_CENTER_Y:  cy <= cfg_mon.data[FOCAL_W-1:0];
          REG_FOCAL_BL:  fb <= cfg_mon.data[FB_W-1:0];
          REG_MIN_DEPTH: zmin <= cfg_mon.data[Z_W-1:0];
          REG_MAX_DEPTH: zmax <= cfg_mon.data[Z_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready &&
          project_pixel(in_mon.disparity_q4, in_mon.column, in_mon.row, p))
        point_queue = {point_queue, p};
      if (out_mon.valid && out_mon.ready) begin
        if (point_queue.size() == 0) begin
          $error("unexpected point transaction");
          errs++;
        end else begin
          got = point_queue.pop_front();
          if (out_mon.point_x_q10 !== got.x) begin
            $error("point_x_q10 exp %0d got %0d", $signed(got.x), out_mon.point_x_q10);
            errs++;
          end
          if (out_mon.point_y_q10 !== got.y) begin
            $error("point_y_q10 exp %0d got %0d", $signed(got.y), out_mon.point_y_q10);
            errs++;
          end
          if (out_mon.point_z_q10 !== got.z) begin
            $error("point_z_q10 exp %0d got %0d", got.z, out_mon.point_z_q10);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ bench/disparity_to_point_reproject_tb.sv @@
module disparity_to_point_reproject_tb;
  import dtp_pkg::*;
  import dtp_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_points;
  int   cycle_count;
  bit   tail_phase;   // no idling near the end of the run

  dtp_in_if  in_ch();
  dtp_out_if out_ch();
  dtp_cfg_if cfg_ch();

  disparity_to_point_reproject uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  point_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_points(pending_points)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result-side backpressure: random stall bursts
  initial begin
    int stall;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!tail_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 19);
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one configuration transaction; valid is dropped again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // drain: all points back, then the pipeline's latency for rejected pixels
  task automatic drain_pipe();
    while (pending_points != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // one pixel transaction, optional idle burst first; valid stays high otherwise
  task automatic send_pixel(input logic [DISP_W-1:0] d,
                            input logic [PIX_W-1:0] u,
                            input logic [PIX_W-1:0] v);
    if (!tail_phase && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1;
    in_ch.disparity_q4 <= d;
    in_ch.column       <= u;
    in_ch.row          <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  // mostly valid disparities, above the rejection threshold
  task automatic random_pixels(input int count);
    logic [DISP_W-1:0] d;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       d = DISP_W'($urandom);                       // anything
        1:       d = DISP_W'($urandom_range(0, 32)) - 16'd16; // at or below threshold
        2:       d = DISP_W'($urandom_range(17, 64));         // far points
        default: d = DISP_W'($urandom_range(17, 4096));
      endcase
      send_pixel(d, PIX_W'($urandom), PIX_W'($urandom));
    end
  endtask

  initial begin
    logic [DISP_W-1:0] corner_disp[10];
    corner_disp = '{16'h8000, 16'hFFFF, 16'h0000, 16'd16, 16'd17, 16'd32,
                    16'd1000, 16'h7FFF, 16'h5555, 16'h2AAA};
    rst_n = 0;
    tail_phase = 0;
    cycle_count = 0;
    in_ch.valid = 0; in_ch.disparity_q4 = '0; in_ch.column = '0; in_ch.row = '0;
    cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: disparity extremes and threshold, pixel extremes, reset calibration
    foreach (corner_disp[i]) send_pixel(corner_disp[i], 12'd0, 12'd4095);
    send_pixel(16'd100, 12'd4095, 12'd0);
    send_pixel(16'd100, 12'd367, 12'd248);   // near principal point
    send_pixel(16'd20, 12'hAAA, 12'h555);
    send_pixel(16'd20, 12'h555, 12'hAAA);
    idle_input();
    drain_pipe();

    // zero focals, zero baseline with open window, index past the register list
    write_reg(REG_FOCAL_X, 24'd0);
    write_reg(REG_FOCAL_Y, 24'd0);
    write_reg(REG_FOCAL_BL, 24'd0);
    write_reg(REG_MIN_DEPTH, 24'd0);
    write_reg(CFG_IDX_W'(NUM_REGS), 24'hFFFFFF);
    send_pixel(16'd17, 12'd4095, 12'd0);
    send_pixel(16'd500, 12'd0, 12'd4095);
    idle_input();
    drain_pipe();

    // full-scale calibration: saturating X, window wide open
    write_reg(REG_FOCAL_X, 24'd1);
    write_reg(REG_FOCAL_Y, 24'hFFFFFF);
    write_reg(REG_CENTER_X, 24'hFFFFFF);
    write_reg(REG_CENTER_Y, 24'd0);
    write_reg(REG_FOCAL_BL, 24'hFFFFFF);
    write_reg(REG_MAX_DEPTH, 24'hFFFFFF);
    send_pixel(16'd17, 12'd0, 12'd4095);
    send_pixel(16'h7FFF, 12'd4095, 12'd4095);
    random_pixels(150);
    idle_input();
    drain_pipe();

    // min above max: nothing passes
    write_reg(REG_MIN_DEPTH, 24'd1000);
    write_reg(REG_MAX_DEPTH, 24'd999);
    random_pixels(50);
    idle_input();
    drain_pipe();

    // several random calibrations
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_FOCAL_X, CFG_DATA_W'($urandom_range(1, 65535)));
      write_reg(REG_FOCAL_Y, CFG_DATA_W'($urandom_range(1, 65535)));
      write_reg(REG_CENTER_X, CFG_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_CENTER_Y, CFG_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_FOCAL_BL, CFG_DATA_W'($urandom_range(0, 1 << 20)));
      write_reg(REG_MIN_DEPTH, CFG_DATA_W'($urandom_range(0, 500)));
      write_reg(REG_MAX_DEPTH, CFG_DATA_W'($urandom_range(20000, 262143)));
      random_pixels(250);
      // sender holds off until every point is back
      idle_input();
      while (pending_points != 0) @(posedge clk);
      random_pixels(30);
      idle_input();
      drain_pipe();
    end

    // back to reset calibration, last stretch without idling
    write_reg(REG_FOCAL_X, CFG_DATA_W'(RST_FOCAL_X));
    write_reg(REG_FOCAL_Y, CFG_DATA_W'(RST_FOCAL_Y));
    write_reg(REG_CENTER_X, CFG_DATA_W'(RST_CENTER_X));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(RST_CENTER_Y));
    write_reg(REG_FOCAL_BL, CFG_DATA_W'(RST_FOCAL_BL));
    write_reg(REG_MIN_DEPTH, CFG_DATA_W'(RST_MIN_DEPTH));
    write_reg(REG_MAX_DEPTH, CFG_DATA_W'(RST_MAX_DEPTH));
    random_pixels(50);
    tail_phase = 1;
    random_pixels(50);
    idle_input();
    drain_pipe();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/dtp_pkg.sv
src/dtp_in_if.sv
src/dtp_out_if.sv
src/dtp_cfg_if.sv
src/dtp_pipe_div.sv
src/disparity_to_point_reproject.sv
bench/dtp_tb_if.sv
bench/point_checker.sv
bench/disparity_to_point_reproject_tb.sv
